@@ rtl/core/rgh_pkg.sv @@
package rgh_pkg;

  // Histogram geometry
  localparam int COUNT_BITS = 32;
  localparam int BINS       = 256;
  localparam int BIN_W      = 8;
  localparam int CH_W       = 8;
  localparam int WEIGHT_W   = 8;
  localparam int REPORT_W   = 32;
  localparam int NUM_HIST   = 4;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RED_RST   = 8'd54;
  localparam logic [WEIGHT_W-1:0] WEIGHT_GREEN_RST = 8'd184;
  localparam logic [WEIGHT_W-1:0] WEIGHT_BLUE_RST  = 8'd18;

  // Histogram lanes
  localparam int LANE_RED   = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_BLUE  = 2;
  localparam int LANE_GRAY  = 3;

  typedef enum logic [1:0] {
    OP_PIXEL    = 2'd0,
    OP_READ     = 2'd1,
    OP_READ_CLR = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_WEIGHT_RED   = 2'd0,
    REG_WEIGHT_GREEN = 2'd1,
    REG_WEIGHT_BLUE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_INC,
    UPD_CLEAR
  } upd_t;

  // Request to one histogram lane, issued in the read stage
  typedef struct packed {
    upd_t             mode;
    logic [BIN_W-1:0] addr;
  } lane_req_t;

  // Saturating increment of one bin count
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] res;
    res = (c == '1) ? c : c + COUNT_BITS'(1);
    return res;
  endfunction

  // Clamp a bin count to the 32-bit result field
  function automatic logic [REPORT_W-1:0] report_count(input logic [COUNT_BITS-1:0] c);
    logic [REPORT_W-1:0] res;
    if (COUNT_BITS > REPORT_W && (c >> REPORT_W) != '0) begin
      res = '1;
    end else begin
      res = REPORT_W'(c);
    end
    return res;
  endfunction

endpackage

@@ rtl/core/rgh_in_if.sv @@
interface rgh_in_if;
  import rgh_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      opcode;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] red;
  logic [BIN_W-1:0] bin;

  modport source(output valid, opcode, blue, green, red, bin, input ready);
  modport sink(input valid, opcode, blue, green, red, bin, output ready);
endinterface

@@ rtl/core/rgh_out_if.sv @@
interface rgh_out_if;
  import rgh_pkg::*;

  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     gray;
  logic [REPORT_W-1:0] red_count;
  logic [REPORT_W-1:0] green_count;
  logic [REPORT_W-1:0] blue_count;
  logic [REPORT_W-1:0] gray_count;

  modport source(output valid, gray, red_count, green_count, blue_count, gray_count,
                 input ready);
  modport sink(input valid, gray, red_count, green_count, blue_count, gray_count,
               output ready);
endinterface

@@ rtl/core/rgh_ram.sv @@
module rgh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rgh_hist_lane.sv @@
module rgh_hist_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rgh_pkg::lane_req_t            req_i,
  output logic [rgh_pkg::COUNT_BITS-1:0] count_o
);
  import rgh_pkg::*;

  lane_req_t             s3_req_r;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] old_cnt;
  logic                  wr_en;
  logic [COUNT_BITS-1:0] wr_data;

  // Last write, registered to cover the read that overlapped it
  logic                  lw_en_r;
  logic [BIN_W-1:0]      lw_addr_r;
  logic [COUNT_BITS-1:0] lw_data_r;

  rgh_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(BINS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s3_req_r.addr),
    .wdata(wr_data),
    .raddr(req_i.addr),
    .rdata(rd_data)
  );

  // Forward the write that landed on the same edge as our read
  assign old_cnt = (lw_en_r && lw_addr_r == s3_req_r.addr) ? lw_data_r : rd_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    unique case (s3_req_r.mode)
      UPD_NONE:  wr_en = 1'b0;
      UPD_INC: begin
        wr_en   = 1'b1;
        wr_data = sat_inc(old_cnt);
      end
      UPD_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      default:   wr_en = 1'b0;
    endcase
  end

  assign count_o = old_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_req_r.mode <= UPD_NONE;
      lw_en_r       <= 1'b0;
    end else begin
      s3_req_r.mode <= req_i.mode;
      lw_en_r       <= wr_en;
    end
    s3_req_r.addr <= req_i.addr;
    lw_addr_r     <= s3_req_r.addr;
    lw_data_r     <= wr_data;
  end

endmodule

@@ rtl/core/rgh_gray_histogram_unit.sv @@
// Channel  Dir  Handshake             Payload
// in_ch    in   valid/ready           opcode, blue, green, red, bin
// out_ch   out  valid/ready           gray, red_count, green_count, blue_count, gray_count
// cfg      in   APB (psel/penable)    weight_red @0x0, weight_green @0x4, weight_blue @0x8
//
// One item per clock sustained while in_ch.ready is high; the four histogram RAMs do a
// read-modify-write per item with a forward of the last write. An item passes
// stages 1 to 3 and the result FIFO on its way to out_ch. After reset a clearing
// pass zeroes all bins with in_ch.ready low. A stalled out_ch fills an 8-entry
// result FIFO; in_ch.ready drops once 8 items are in flight.
module rgb_gray_histogram_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  rgh_in_if.sink                          in_ch,
  rgh_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgh_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rgh_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rgh_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rgh_pkg::*;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int INFL_W     = CNT_W + 1;
  localparam int SUM_W      = 2 * CH_W + 2;

  typedef struct packed {
    logic [CH_W-1:0]     gray;
    logic [REPORT_W-1:0] red_count;
    logic [REPORT_W-1:0] green_count;
    logic [REPORT_W-1:0] blue_count;
    logic [REPORT_W-1:0] gray_count;
  } result_t;

  // Weights
  logic [WEIGHT_W-1:0] w_red_r, w_green_r, w_blue_r;
  reg_idx_t            cfg_idx;

  // Clearing pass
  logic             clr_active_r;
  logic [BIN_W-1:0] clr_addr_r;

  // Stage 1: accepted item
  logic             s1_valid_r;
  op_t              s1_op_r;
  logic [CH_W-1:0]  s1_r_r, s1_g_r, s1_b_r;
  logic [BIN_W-1:0] s1_bin_r;
  logic [SUM_W-1:0] s1_sum;
  logic [CH_W-1:0]  s1_gray;

  // Stage 2: gray known, RAM read issued
  logic             s2_valid_r;
  op_t              s2_op_r;
  logic [CH_W-1:0]  s2_r_r, s2_g_r, s2_b_r, s2_gray_r;
  logic [BIN_W-1:0] s2_bin_r;
  lane_req_t        lane_req [NUM_HIST];

  // Stage 3: read data back, write-back and result
  logic                  s3_valid_r;
  op_t                   s3_op_r;
  logic [CH_W-1:0]       s3_gray_r;
  logic [COUNT_BITS-1:0] lane_cnt [NUM_HIST];
  result_t               res;

  // Result FIFO
  result_t          fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fifo_cnt_r;
  logic             push, pop;
  logic [INFL_W-1:0] in_flight;
  logic             in_xfer;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_WEIGHT_RED:   prdata = CFG_DATA_W'(w_red_r);
      REG_WEIGHT_GREEN: prdata = CFG_DATA_W'(w_green_r);
      REG_WEIGHT_BLUE:  prdata = CFG_DATA_W'(w_blue_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_red_r   <= WEIGHT_RED_RST;
      w_green_r <= WEIGHT_GREEN_RST;
      w_blue_r  <= WEIGHT_BLUE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_WEIGHT_RED:   w_red_r   <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_GREEN: w_green_r <= pwdata[WEIGHT_W-1:0];
        REG_WEIGHT_BLUE:  w_blue_r  <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input acceptance: room for every item in flight, no clearing pass
  assign in_flight = INFL_W'(s1_valid_r) + INFL_W'(s2_valid_r) + INFL_W'(s3_valid_r)
                   + INFL_W'(fifo_cnt_r);
  assign in_ch.ready = !clr_active_r && (in_flight < INFL_W'(FIFO_DEPTH));
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Clearing pass after reset, one bin per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + BIN_W'(1);
      if (clr_addr_r == '1) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Stage 1: weighted sum, truncated and saturated
  assign s1_sum = SUM_W'(w_red_r * s1_r_r) + SUM_W'(w_green_r * s1_g_r)
                + SUM_W'(w_blue_r * s1_b_r);
  assign s1_gray = (s1_sum[SUM_W-1:2*CH_W] != '0) ? '1 : s1_sum[2*CH_W-1:CH_W];

  // Stage 2: lane requests
  always_comb begin
    upd_t mode;
    mode = UPD_NONE;
    if (s2_valid_r) begin
      unique case (s2_op_r)
        OP_PIXEL:    mode = UPD_INC;
        OP_READ:     mode = UPD_NONE;
        OP_READ_CLR: mode = UPD_CLEAR;
        OP_NOP:      mode = UPD_NONE;
        default:     mode = UPD_NONE;
      endcase
    end
    if (clr_active_r) begin
      for (int k = 0; k < NUM_HIST; k++) begin
        lane_req[k].mode = UPD_CLEAR;
        lane_req[k].addr = clr_addr_r;
      end
    end else if (s2_op_r == OP_PIXEL) begin
      for (int k = 0; k < NUM_HIST; k++) begin
        lane_req[k].mode = mode;
      end
      lane_req[LANE_RED].addr   = s2_r_r;
      lane_req[LANE_GREEN].addr = s2_g_r;
      lane_req[LANE_BLUE].addr  = s2_b_r;
      lane_req[LANE_GRAY].addr  = s2_gray_r;
    end else begin
      for (int k = 0; k < NUM_HIST; k++) begin
        lane_req[k].mode = mode;
        lane_req[k].addr = s2_bin_r;
      end
    end
  end

  // Histogram lanes
  for (genvar k = 0; k < NUM_HIST; k++) begin : g_lane
    rgh_hist_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .req_i  (lane_req[k]),
      .count_o(lane_cnt[k])
    );
  end

  // Stage 3: result assembly
  always_comb begin
    res = '0;
    unique case (s3_op_r)
      OP_PIXEL: res.gray = s3_gray_r;
      OP_READ, OP_READ_CLR: begin
        res.red_count   = report_count(lane_cnt[LANE_RED]);
        res.green_count = report_count(lane_cnt[LANE_GREEN]);
        res.blue_count  = report_count(lane_cnt[LANE_BLUE]);
        res.gray_count  = report_count(lane_cnt[LANE_GRAY]);
      end
      OP_NOP:   res = '0;
      default:  res = '0;
    endcase
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
    s1_op_r   <= op_t'(in_ch.opcode);
    s1_r_r    <= in_ch.red;
    s1_g_r    <= in_ch.green;
    s1_b_r    <= in_ch.blue;
    s1_bin_r  <= in_ch.bin;
    s2_op_r   <= s1_op_r;
    s2_r_r    <= s1_r_r;
    s2_g_r    <= s1_g_r;
    s2_b_r    <= s1_b_r;
    s2_bin_r  <= s1_bin_r;
    s2_gray_r <= s1_gray;
    s3_op_r   <= s2_op_r;
    s3_gray_r <= s2_gray_r;
  end

  // Result FIFO
  assign push = s3_valid_r;
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) begin
      fifo_q[wr_ptr_r] <= res;
    end
  end

  assign out_ch.valid       = (fifo_cnt_r != '0);
  assign out_ch.gray        = fifo_q[rd_ptr_r].gray;
  assign out_ch.red_count   = fifo_q[rd_ptr_r].red_count;
  assign out_ch.green_count = fifo_q[rd_ptr_r].green_count;
  assign out_ch.blue_count  = fifo_q[rd_ptr_r].blue_count;
  assign out_ch.gray_count  = fifo_q[rd_ptr_r].gray_count;

endmodule
